// ===== rtl/pcf_pkg.sv =====
`timescale 1ns / 1ps

package pcf_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 47;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KI   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OLIM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ILIM = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ESL  = 3'd6;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_FILT  = 2'd1;
  localparam logic [1:0] MODE_INCR  = 2'd2;

  localparam logic [31:0] KP_RST   = 32'd42598;
  localparam logic [31:0] KI_RST   = 32'd6554;
  localparam logic [31:0] KD_RST   = 32'd0;
  localparam logic [30:0] OLIM_RST = 31'd671088640;
  localparam logic [30:0] ILIM_RST = 31'd335544320;
  localparam logic [46:0] ESL_RST  = 47'd3858759680;

  // Shared multiplier: signed operand times unsigned operand.
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] kp;
    logic [31:0] ki;
    logic [31:0] kd;
    logic [30:0] olim;
    logic [30:0] ilim;
    logic [46:0] esl;
  } cfg_t;

  typedef struct packed {
    logic               action;
    logic signed [31:0] measured;
    logic signed [31:0] setpoint;
  } req_t;

endpackage

// ===== rtl/pcf_mul.sv =====
`timescale 1ns / 1ps

module pcf_mul import pcf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic        [MUL_B_W-1:0] b_i,
  output logic signed [MUL_P_W-1:0] p_o
);

  logic signed [MUL_P_W-1:0] p_q;
  logic signed [MUL_P_W-1:0] p_d;
  logic signed [MUL_B_W:0]   b_s;

  assign b_s = $signed({1'b0, b_i});
  assign p_d = MUL_P_W'(a_i) * MUL_P_W'(b_s);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/pcf_core.sv =====
`timescale 1ns / 1ps

module pcf_core import pcf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               start_i,
  input  req_t               req_i,
  output logic               busy_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic signed [31:0] res_data_o
);

  localparam int SAT_W  = MUL_P_W + 1;
  localparam int CLP_W  = 50;
  localparam int LIM_W  = CLP_W - 1;
  localparam int X_W    = 50;
  localparam int HI_W   = X_W - 32 + MUL_B_W;
  localparam int R_W    = 66;
  localparam int ESUM_W = 48;
  localparam int SUMX_W = ESUM_W + 1;
  localparam int MAG_W  = 41;

  localparam logic [MUL_B_W-1:0] W95 = MUL_B_W'(((95 << FRAC_BITS) + 50) / 100);
  localparam logic [MUL_B_W-1:0] W85 = MUL_B_W'(((85 << FRAC_BITS) + 50) / 100);
  localparam logic signed [SAT_W-1:0] BL_HALF = SAT_W'(1) <<< (FRAC_BITS - 1);
  localparam logic [HI_W-1:0]  HI_CAP   = HI_W'(1) << (8 + FRAC_BITS);
  localparam logic [MAG_W-1:0] TERM_CAP = MAG_W'(1) << 40;

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_MF_MUL   = 5'd1;
  localparam logic [4:0] ST_MF_DONE  = 5'd2;
  localparam logic [4:0] ST_ERR      = 5'd3;
  localparam logic [4:0] ST_ERR_MUL  = 5'd4;
  localparam logic [4:0] ST_ERR_DONE = 5'd5;
  localparam logic [4:0] ST_SUM      = 5'd6;
  localparam logic [4:0] ST_G_LOAD   = 5'd7;
  localparam logic [4:0] ST_G_LO     = 5'd8;
  localparam logic [4:0] ST_G_HI     = 5'd9;
  localparam logic [4:0] ST_G_SUM    = 5'd10;
  localparam logic [4:0] ST_G_FIN    = 5'd11;
  localparam logic [4:0] ST_D_DIFF   = 5'd12;
  localparam logic [4:0] ST_D_MUL    = 5'd13;
  localparam logic [4:0] ST_D_DONE   = 5'd14;
  localparam logic [4:0] ST_PID      = 5'd15;
  localparam logic [4:0] ST_O_MUL    = 5'd16;
  localparam logic [4:0] ST_O_DONE   = 5'd17;
  localparam logic [4:0] ST_CLAMP    = 5'd18;
  localparam logic [4:0] ST_OUT      = 5'd19;

  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-32:0] top;
    top = v[SAT_W-1:31];
    if ((&top) || !(|top)) begin
      return v[31:0];
    end
    return v[SAT_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  function automatic logic signed [CLP_W-1:0] clamp_sym(input logic signed [CLP_W-1:0] v,
                                                        input logic [LIM_W-1:0] lim);
    logic signed [CLP_W-1:0] lim_s;
    lim_s = $signed({1'b0, lim});
    if (v > lim_s) begin
      return lim_s;
    end
    if (v < -lim_s) begin
      return -lim_s;
    end
    return v;
  endfunction

  // Controller state.
  logic signed [31:0]       mf_q, en_q, ep_q, ep2_q, dp_q, op_q;
  logic signed [ESUM_W-1:0] es_q;

  // Working registers of one step.
  logic [4:0]                state_q;
  logic [1:0]                term_q;
  req_t                      req_q;
  logic signed [31:0]        enew_q, p_q, i_q, d_q, res_q;
  logic signed [SUMX_W-1:0]  sum_q;
  logic signed [MUL_A_W-1:0] diff_q, o_raw_q;
  logic [X_W-1:0]            m_q;
  logic                      neg_q, big_q;
  logic [63:0]               lo_q;
  logic [R_W-1:0]            r_q;

  logic                      plain, incr;
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [MUL_P_W-1:0] prod;

  logic signed [31:0]        bl_base;
  logic signed [SAT_W-1:0]   bl_sum, bl_res;
  logic signed [31:0]        bl_sat;
  logic signed [31:0]        e0;

  logic signed [X_W-1:0]     gx;
  logic [X_W-1:0]            gm_d;
  logic [MUL_B_W-1:0]        gsel;
  logic [HI_W-1:0]           hi;
  logic [R_W-1:0]            r_d;
  logic                      big_d;
  logic [MAG_W-1:0]          gmag;
  logic signed [MAG_W:0]     gval;
  logic signed [31:0]        g_sat;
  logic signed [CLP_W-1:0]   g_clip;

  logic signed [MUL_A_W-1:0] pid;
  logic signed [CLP_W-1:0]   o_clip, es_clip;

  assign plain = (cfg_i.mode == MODE_PLAIN);
  assign incr  = (cfg_i.mode == MODE_INCR);

  pcf_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_comb begin
    case (term_q)
      TERM_I:  gsel = cfg_i.ki;
      TERM_D:  gsel = cfg_i.kd;
      default: gsel = cfg_i.kp;
    endcase
  end

  always_comb begin
    mul_en = 1'b0;
    mul_a  = diff_q;
    mul_b  = W85;
    case (state_q)
      ST_MF_MUL: begin
        mul_en = 1'b1;
        mul_b  = W95;
      end
      ST_ERR_MUL, ST_D_MUL, ST_O_MUL: begin
        mul_en = 1'b1;
      end
      ST_G_LO: begin
        mul_en = 1'b1;
        mul_a  = $signed(MUL_A_W'(m_q[31:0]));
        mul_b  = gsel;
      end
      ST_G_HI: begin
        mul_en = 1'b1;
        mul_a  = $signed(MUL_A_W'(m_q[X_W-1:32]));
        mul_b  = gsel;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // A blend a*w + b*(1-w) is formed as b*2^F + (a-b)*w, rounded half up.
  always_comb begin
    case (state_q)
      ST_ERR_DONE: bl_base = en_q;
      ST_D_DONE:   bl_base = dp_q;
      ST_O_DONE:   bl_base = op_q;
      default:     bl_base = mf_q;
    endcase
    bl_sum = SAT_W'(prod) + (SAT_W'(bl_base) <<< FRAC_BITS) + BL_HALF;
    bl_res = bl_sum >>> FRAC_BITS;
    bl_sat = sat32(bl_res);
  end

  assign e0 = sat32(SAT_W'(req_q.setpoint) - SAT_W'(mf_q));

  always_comb begin
    case (term_q)
      TERM_P: gx = incr ? X_W'(enew_q) - X_W'(en_q) : X_W'(enew_q);
      TERM_I: gx = incr ? X_W'(enew_q) : X_W'(sum_q);
      TERM_D: gx = incr ? X_W'(enew_q) - (X_W'(en_q) <<< 1) + X_W'(ep_q)
                        : X_W'(enew_q) - X_W'(en_q);
      default: gx = X_W'(enew_q);
    endcase
    gm_d = gx[X_W-1] ? $unsigned(-gx) : $unsigned(gx);
  end

  // Gain product: magnitude split at bit 32, rounded to nearest, capped at 2^40.
  assign hi    = prod[HI_W-1:0];
  assign big_d = (hi > HI_CAP);
  assign r_d   = (R_W'(hi) << (32 - FRAC_BITS)) + R_W'(lo_q >> FRAC_BITS)
               + R_W'(lo_q[FRAC_BITS-1]);

  always_comb begin
    gmag   = (big_q || (r_q > R_W'(TERM_CAP))) ? TERM_CAP : r_q[MAG_W-1:0];
    gval   = neg_q ? -$signed({1'b0, gmag}) : $signed({1'b0, gmag});
    g_sat  = sat32(SAT_W'(gval));
    g_clip = clamp_sym(CLP_W'(gval), LIM_W'(cfg_i.ilim));
  end

  assign pid     = MUL_A_W'(p_q) + MUL_A_W'(i_q) + MUL_A_W'(d_q);
  assign o_clip  = clamp_sym(CLP_W'(o_raw_q), LIM_W'(cfg_i.olim));
  assign es_clip = clamp_sym(CLP_W'(sum_q), LIM_W'(cfg_i.esl));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      term_q  <= TERM_P;
      mf_q    <= '0;
      en_q    <= '0;
      ep_q    <= '0;
      ep2_q   <= '0;
      dp_q    <= '0;
      op_q    <= '0;
      es_q    <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            req_q <= req_i;
            if (req_i.action) begin
              mf_q    <= '0;
              en_q    <= '0;
              ep_q    <= '0;
              ep2_q   <= '0;
              dp_q    <= '0;
              op_q    <= '0;
              es_q    <= '0;
              res_q   <= '0;
              state_q <= ST_OUT;
            end else if (plain) begin
              mf_q    <= req_i.measured;
              state_q <= ST_ERR;
            end else begin
              diff_q  <= MUL_A_W'(req_i.measured) - MUL_A_W'(mf_q);
              state_q <= ST_MF_MUL;
            end
          end
        end
        ST_MF_MUL: begin
          state_q <= ST_MF_DONE;
        end
        ST_MF_DONE: begin
          mf_q    <= bl_sat;
          state_q <= ST_ERR;
        end
        ST_ERR: begin
          if (plain) begin
            enew_q  <= e0;
            state_q <= ST_SUM;
          end else begin
            diff_q  <= MUL_A_W'(e0) - MUL_A_W'(en_q);
            state_q <= ST_ERR_MUL;
          end
        end
        ST_ERR_MUL: begin
          state_q <= ST_ERR_DONE;
        end
        ST_ERR_DONE: begin
          enew_q  <= bl_sat;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          sum_q   <= SUMX_W'(es_q) + SUMX_W'(enew_q);
          term_q  <= TERM_P;
          state_q <= ST_G_LOAD;
        end
        ST_G_LOAD: begin
          m_q     <= gm_d;
          neg_q   <= gx[X_W-1];
          state_q <= ST_G_LO;
        end
        ST_G_LO: begin
          state_q <= ST_G_HI;
        end
        ST_G_HI: begin
          lo_q    <= prod[63:0];
          state_q <= ST_G_SUM;
        end
        ST_G_SUM: begin
          r_q     <= r_d;
          big_q   <= big_d;
          state_q <= ST_G_FIN;
        end
        ST_G_FIN: begin
          case (term_q)
            TERM_P: begin
              p_q     <= g_sat;
              term_q  <= TERM_I;
              state_q <= ST_G_LOAD;
            end
            TERM_I: begin
              i_q     <= g_clip[31:0];
              term_q  <= TERM_D;
              state_q <= ST_G_LOAD;
            end
            default: begin
              d_q     <= g_sat;
              state_q <= plain ? ST_PID : ST_D_DIFF;
            end
          endcase
        end
        ST_D_DIFF: begin
          diff_q  <= MUL_A_W'(d_q) - MUL_A_W'(dp_q);
          state_q <= ST_D_MUL;
        end
        ST_D_MUL: begin
          state_q <= ST_D_DONE;
        end
        ST_D_DONE: begin
          d_q     <= bl_sat;
          dp_q    <= bl_sat;
          state_q <= ST_PID;
        end
        ST_PID: begin
          if (plain) begin
            o_raw_q <= pid;
            dp_q    <= d_q;
            state_q <= ST_CLAMP;
          end else begin
            diff_q  <= incr ? pid : pid - MUL_A_W'(op_q);
            state_q <= ST_O_MUL;
          end
        end
        ST_O_MUL: begin
          state_q <= ST_O_DONE;
        end
        ST_O_DONE: begin
          o_raw_q <= bl_res[MUL_A_W-1:0];
          state_q <= ST_CLAMP;
        end
        ST_CLAMP: begin
          op_q  <= o_clip[31:0];
          res_q <= o_clip[31:0];
          es_q  <= es_clip[ESUM_W-1:0];
          if (!plain) begin
            ep2_q <= ep_q;
          end
          ep_q    <= en_q;
          en_q    <= enew_q;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_OUT);
  assign res_data_o  = res_q;

endmodule

// ===== rtl/pid_controller_filtered_top.sv =====
`timescale 1ns / 1ps

// Filtered PID controller with one shared multiplier.
// The input channel (in_valid_i / in_stall_o) carries an action bit, a measured
// value and a setpoint, all Q16.16 by default. A transfer takes place at a rising
// edge where valid is high and stall is low. Every transfer gives exactly one
// drive value on the output channel (out_valid_o / out_stall_i).
// A control step runs through a sequencer that uses one registered multiplier
// for the filter blends and, in five steps each, for the three gain products.
// The filtered modes add blend steps that the plain mode skips, and a clear action
// goes straight to the result; in_stall_o stays high until the result has been
// handed to the output register, and only then can the next input transfer follow.
// The finished value moves into an output register, so a new input transfer
// may start while the receiver still stalls the previous result; the sequencer
// only waits when that register is still occupied.
// Registers are written through cfg_valid_i / cfg_index_i / cfg_data_i, which
// are always ready; writes are expected only while the block is idle.
// Reset loads the register defaults and zeroes all controller state.

module pid_controller_filtered_top import pcf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  action_i,
  input  logic signed [31:0]    measured_i,
  input  logic signed [31:0]    setpoint_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [31:0]    control_out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t               cfg_q;
  req_t               req;
  logic               busy;
  logic               start;
  logic               res_valid;
  logic               res_ready;
  logic signed [31:0] res_data;
  logic               out_valid_q;
  logic signed [31:0] out_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= MODE_FILT;
      cfg_q.kp   <= KP_RST;
      cfg_q.ki   <= KI_RST;
      cfg_q.kd   <= KD_RST;
      cfg_q.olim <= OLIM_RST;
      cfg_q.ilim <= ILIM_RST;
      cfg_q.esl  <= ESL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MODE: cfg_q.mode <= cfg_data_i[1:0];
        CFG_KP:   cfg_q.kp   <= cfg_data_i[31:0];
        CFG_KI:   cfg_q.ki   <= cfg_data_i[31:0];
        CFG_KD:   cfg_q.kd   <= cfg_data_i[31:0];
        CFG_OLIM: cfg_q.olim <= cfg_data_i[30:0];
        CFG_ILIM: cfg_q.ilim <= cfg_data_i[30:0];
        CFG_ESL:  cfg_q.esl  <= cfg_data_i[46:0];
        default: begin
        end
      endcase
    end
  end

  assign req.action   = action_i;
  assign req.measured = measured_i;
  assign req.setpoint = setpoint_i;

  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;
  assign res_ready  = !out_valid_q || !out_stall_i;

  pcf_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (start),
    .req_i       (req),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign control_out_o = out_data_q;

endmodule
